### rtl/bucketed_hash_set_top_macros.svh
// Assertion helpers for the bucketed hash set.
// All checks are sampled on the rising edge of clk_i and held off while in reset.
`ifndef BUCKETED_HASH_SET_TOP_MACROS_SVH
`define BUCKETED_HASH_SET_TOP_MACROS_SVH

// Same-cycle implication.
`define BHS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BHS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bhs_pkg.sv
`timescale 1ns / 1ps

package bhs_pkg;

  // operation codes on func
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam int unsigned KEY_W = 31;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_MLO   = 10'b0000000100,
    S_MHI   = 10'b0000001000,
    S_MQB   = 10'b0000010000,
    S_FIX   = 10'b0000100000,
    S_RDV   = 10'b0001000000,
    S_VLD   = 10'b0010000000,
    S_SCAN  = 10'b0100000000,
    S_DEC   = 10'b1000000000
  } state_e;

endpackage

### rtl/bhs_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read data.
module bhs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/bucketed_hash_set_top.sv
// Sequence from input transfer to result valid: key mod BUCKETS on one shared multiplier
//   (reciprocal low half, high half, quotient estimate times BUCKETS) and a correction, then a
//   bucket valid-row read, one key-RAM read per way scanned (1..WAYS) through the single comparator,
//   and a decision, held while an earlier result waits; a new request is accepted only in idle.
// Reset: asynchronous, active low. Afterwards a clearing pass writes zero to the valid row
//   of every bucket, one bucket per cycle, with in_ready_o held low.
`timescale 1ns / 1ps

module bucketed_hash_set_top #(
  parameter int unsigned BUCKETS = 16,
  parameter int unsigned WAYS    = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [30:0] key_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic [1:0]  status_o
);

  // Bucket index and way index widths. The key RAM is addressed {bucket, way},
  // so both RAMs are sized to powers of two; rows beyond BUCKETS are never used.
  localparam int unsigned BI     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned VDEPTH = 1 << BI;
  localparam int unsigned KDEPTH = (1 << BI) * (1 << WAY_W);
  localparam int unsigned KEY_W  = bhs_pkg::KEY_W;

  localparam logic [BI:0]    BUCKETS_C = (BI + 1)'(BUCKETS);
  localparam logic [BI-1:0]  LAST_BKT  = BI'(BUCKETS - 1);
  localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);

  // Reciprocal floor(2^31 / BUCKETS). The quotient estimate key * RECIP >> 31 is at
  // most one short, so one compare and subtract finishes the remainder.
  localparam logic [31:0] RECIP_C  = 32'(64'd2147483648 / 64'(BUCKETS));
  localparam logic [15:0] RECIP_LO = RECIP_C[15:0];
  localparam logic [15:0] RECIP_HI = RECIP_C[31:16];
  localparam logic [15:0] BKT_MUL  = 16'(BUCKETS);

  bhs_pkg::state_e state_q, state_d;

  // control
  logic [BI-1:0]    clr_q, clr_d;         // clearing pass row
  logic [WAY_W-1:0] way_q, way_d;         // way being compared
  logic             found_q, found_d;
  logic             out_valid_q, out_valid_d;

  // payload
  logic [1:0]       func_q, func_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [62:0]      prod_q, prod_d;       // multiplier accumulator
  logic [BI-1:0]    rem_q, rem_d;         // bucket index
  logic [WAYS-1:0]  vrow_q, vrow_d;       // valid bits of the bucket
  logic [WAY_W-1:0] hit_way_q, hit_way_d;
  logic             hit_q, hit_d;
  logic [1:0]       status_q, status_d;

  // RAM ports
  logic                   k_we;
  logic [BI+WAY_W-1:0]    k_waddr, k_raddr;
  logic [KEY_W-1:0]       k_rdata;
  logic                   v_we;
  logic [BI-1:0]          v_waddr;
  logic [WAYS-1:0]        v_wdata, v_rdata;

  // shared multiplier, 31 x 16
  logic [30:0]      mul_a;
  logic [15:0]      mul_b;
  logic [46:0]      mul_p;

  // remainder correction: estimate lies in [0, 2*BUCKETS), low bits suffice
  logic [BI:0]      rem_sh;
  logic [BI-1:0]    rem_nx;

  // lowest free way of the bucket
  logic [WAY_W-1:0] free_way;
  logic             free_any;

  logic             in_xfer, out_xfer, out_stall, key_eq;
  logic [WAY_W-1:0] way_rd;

  assign in_xfer   = in_valid_i && in_ready_o;
  assign out_xfer  = out_valid_q && out_ready_i;
  // a finished result may only be registered once the previous one has gone
  assign out_stall = out_valid_q && !out_ready_i;
  assign key_eq    = (k_rdata == key_q);

  // low half of the reciprocal, high half, then quotient estimate times BUCKETS
  always_comb begin
    mul_a = key_q;
    mul_b = RECIP_LO;
    case (state_q)
      bhs_pkg::S_MHI: begin
        mul_b = RECIP_HI;
      end
      bhs_pkg::S_MQB: begin
        mul_a = prod_q[61:31];
        mul_b = BKT_MUL;
      end
      default: begin
        mul_b = RECIP_LO;
      end
    endcase
  end

  assign mul_p = {16'b0, mul_a} * {31'b0, mul_b};

  always_comb begin
    rem_sh = key_q[BI:0] - prod_q[BI:0];
    if (rem_sh >= BUCKETS_C) begin
      rem_sh = rem_sh - BUCKETS_C;
    end
    rem_nx = rem_sh[BI-1:0];
  end

  always_comb begin
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!vrow_q[w]) begin
        free_way = WAY_W'(w);
      end
    end
    free_any = ~&vrow_q;
  end

  // key RAM read address runs one way ahead of the compare
  assign way_rd  = (state_q == bhs_pkg::S_SCAN) ? way_q + 1'b1 : '0;
  assign k_raddr = {rem_q, way_rd};

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    way_d       = way_q;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    func_d      = func_q;
    key_d       = key_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    vrow_d      = vrow_q;
    hit_way_d   = hit_way_q;
    hit_d       = hit_q;
    status_d    = status_q;
    k_we        = 1'b0;
    k_waddr     = {rem_q, free_way};
    v_we        = 1'b0;
    v_waddr     = rem_q;
    v_wdata     = vrow_q;

    if (out_xfer) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      bhs_pkg::S_CLEAR: begin
        v_we    = 1'b1;
        v_waddr = clr_q;
        v_wdata = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == LAST_BKT) begin
          state_d = bhs_pkg::S_IDLE;
        end
      end
      bhs_pkg::S_IDLE: begin
        if (in_xfer) begin
          func_d   = func_i;
          key_d    = key_i;
          found_d  = 1'b0;
          state_d  = bhs_pkg::S_MLO;
        end
      end
      bhs_pkg::S_MLO: begin
        prod_d  = {16'b0, mul_p};
        state_d = bhs_pkg::S_MHI;
      end
      bhs_pkg::S_MHI: begin
        prod_d  = prod_q + {mul_p, 16'b0};
        state_d = bhs_pkg::S_MQB;
      end
      bhs_pkg::S_MQB: begin
        prod_d  = {16'b0, mul_p};
        state_d = bhs_pkg::S_FIX;
      end
      bhs_pkg::S_FIX: begin
        rem_d   = rem_nx;
        state_d = bhs_pkg::S_RDV;
      end
      bhs_pkg::S_RDV: begin
        // valid row read issued at rem_q, key of way 0 issued as well
        state_d = bhs_pkg::S_VLD;
      end
      bhs_pkg::S_VLD: begin
        vrow_d  = v_rdata;
        way_d   = '0;
        state_d = bhs_pkg::S_SCAN;
      end
      bhs_pkg::S_SCAN: begin
        if (vrow_q[way_q] && key_eq) begin
          found_d   = 1'b1;
          hit_way_d = way_q;
          state_d   = bhs_pkg::S_DEC;
        end else if (way_q == LAST_WAY) begin
          state_d = bhs_pkg::S_DEC;
        end else begin
          way_d = way_q + 1'b1;
        end
      end
      bhs_pkg::S_DEC: begin
        if (!out_stall) begin
          hit_d       = found_q;
          out_valid_d = 1'b1;
          state_d     = bhs_pkg::S_IDLE;
          case (func_q)
            bhs_pkg::OP_INSERT: begin
              if (found_q) begin
                status_d = bhs_pkg::ST_PRESENT;
              end else if (free_any) begin
                k_we     = 1'b1;
                v_we     = 1'b1;
                v_wdata  = vrow_q | (WAYS'(1) << free_way);
                status_d = bhs_pkg::ST_DONE;
              end else begin
                status_d = bhs_pkg::ST_FULL;
              end
            end
            bhs_pkg::OP_DELETE: begin
              if (found_q) begin
                v_we     = 1'b1;
                v_wdata  = vrow_q & ~(WAYS'(1) << hit_way_q);
                status_d = bhs_pkg::ST_DONE;
              end else begin
                status_d = bhs_pkg::ST_MISSING;
              end
            end
            default: begin
              // search, and the unused fourth code behaves as a search
              status_d = found_q ? bhs_pkg::ST_DONE : bhs_pkg::ST_MISSING;
            end
          endcase
        end
      end
      default: begin
        state_d = bhs_pkg::S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bhs_pkg::S_CLEAR;
      clr_q       <= '0;
      way_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      way_q       <= way_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    key_q     <= key_d;
    prod_q    <= prod_d;
    rem_q     <= rem_d;
    vrow_q    <= vrow_d;
    hit_way_q <= hit_way_d;
    hit_q     <= hit_d;
    status_q  <= status_d;
  end

  bhs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (KDEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .waddr_i (k_waddr),
    .wdata_i (key_q),
    .raddr_i (k_raddr),
    .rdata_o (k_rdata)
  );

  bhs_ram #(
    .WIDTH (WAYS),
    .DEPTH (VDEPTH)
  ) u_valid_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .raddr_i (rem_q),
    .rdata_o (v_rdata)
  );

  assign in_ready_o  = (state_q == bhs_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign status_o    = status_q;

`include "bucketed_hash_set_top_macros.svh"

  `BHS_ASSERT_NXT(a_accept_starts_mod, in_xfer, state_q == bhs_pkg::S_MLO, "transfer did not start remainder")
  `BHS_ASSERT_IMP(a_key_we_insert, k_we, (state_q == bhs_pkg::S_DEC) && (func_q == bhs_pkg::OP_INSERT) && !found_q, "key write outside insert")
  `BHS_ASSERT_IMP(a_hit_way_valid, (state_q == bhs_pkg::S_DEC) && found_q, vrow_q[hit_way_q], "hit way not valid")
  `BHS_ASSERT_NXT(a_result_posted, (state_q == bhs_pkg::S_DEC) && !out_stall, out_valid_o && in_ready_o, "result not posted")

endmodule

### bench/bucketed_hash_set_top_tb.sv
`timescale 1ns / 1ps

module bucketed_hash_set_top_tb;

  // Geometry of the block under test; the mirror below uses the same values.
  localparam int unsigned BUCKETS = 16;
  localparam int unsigned WAYS    = 4;
  localparam int unsigned SLOTS   = BUCKETS * WAYS;

  // The spare operation code, which the block treats as a search.
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int RANDOM_ITEMS = 1030;
  // Worst case per request is the block work, the longest sender gap and receiver stall,
  // plus the two long hold-offs, summed over all requests. Taken ~6x over.
  localparam int CYCLE_LIMIT  = 600000;
  // Settling time after the last result: room for one full request and some margin.
  localparam int TAIL_CYCLES  = 80;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i      = bhs_pkg::OP_SEARCH;
  logic [30:0] key_i       = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        hit_o;
  logic [1:0]  status_o;

  bucketed_hash_set_top #(
    .BUCKETS(BUCKETS),
    .WAYS   (WAYS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .key_i      (key_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .hit_o      (hit_o),
    .status_o   (status_o)
  );

  // One predicted answer, kept with the request that caused it for the reports.
  typedef struct packed {
    logic [1:0]  op;
    logic [30:0] req_key;
    logic        hit;
    logic [1:0]  status;
  } outcome_t;

  // Mirror of the table plus the queue of answers still owed by the block.
  class hash_set_scoreboard;
    logic [bhs_pkg::KEY_W-1:0] slot_key [SLOTS];
    bit               slot_used[SLOTS];
    outcome_t         pending_outcomes[$];
    int               failures;
    int               op_seen[4];
    int               status_seen[4];
    int               hits_seen;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_key[i]  = '0;
      end
    endfunction

    function int pending();
      return pending_outcomes.size();
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%0t ns: %s", $realtime, msg);
    endfunction

    // Input transfer: update the mirror and queue what the block must answer.
    function void note_request(logic [1:0] op, logic [30:0] req_key);
      int unsigned base;
      int          found;
      int          spare;
      outcome_t    o;
      base  = (req_key % BUCKETS) * WAYS;
      found = -1;
      spare = -1;
      for (int w = 0; w < WAYS; w++) begin
        if (found < 0 && slot_used[base + w] && slot_key[base + w] == req_key) found = w;
        if (spare < 0 && !slot_used[base + w]) spare = w;
      end
      o.op      = op;
      o.req_key = req_key;
      o.hit     = (found >= 0);
      case (op)
        bhs_pkg::OP_INSERT: begin
          if (found >= 0) begin
            o.status = bhs_pkg::ST_PRESENT;
          end else if (spare >= 0) begin
            // lowest free way takes the key
            slot_key[base + spare]  = req_key;
            slot_used[base + spare] = 1'b1;
            o.status = bhs_pkg::ST_DONE;
          end else begin
            o.status = bhs_pkg::ST_FULL;
          end
        end
        bhs_pkg::OP_DELETE: begin
          if (found >= 0) begin
            slot_used[base + found] = 1'b0;
            o.status = bhs_pkg::ST_DONE;
          end else begin
            o.status = bhs_pkg::ST_MISSING;
          end
        end
        // search and spare code
        default: o.status = (found >= 0) ? bhs_pkg::ST_DONE : bhs_pkg::ST_MISSING;
      endcase
      op_seen[op]++;
      status_seen[o.status]++;
      if (o.hit) hits_seen++;
      pending_outcomes.push_back(o);
    endfunction

    // Output transfer: compare against the oldest outstanding answer.
    function void check_result(logic hit, logic [1:0] status);
      outcome_t o;
      if (pending_outcomes.size() == 0) begin
        flag($sformatf("result hit=%0d status=%0d with no request outstanding", hit, status));
        return;
      end
      o = pending_outcomes.pop_front();
      if (hit !== o.hit)
        flag($sformatf("hit mismatch, op %0d key %h: expected %0d, got %0d",
                       o.op, o.req_key, o.hit, hit));
      if (status !== o.status)
        flag($sformatf("status mismatch, op %0d key %h: expected %0d, got %0d",
                       o.op, o.req_key, o.status, status));
    endfunction
  endclass

  hash_set_scoreboard sb = new();

  // 2 ns clock.
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
        $display("bucketed_hash_set_top_tb NOT OK");
        $finish;
      end
    end
  end

  // Both monitors sample the pre-edge values, so the ordering against the driving
  // processes (all nonblocking) within the step does not matter.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_request(func_i, key_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(hit_o, status_o);
  end

  // Receiver: runs of a randomly chosen stall pattern, with two long hold-offs counted
  // here. The block holds only a request or two, so during a hold-off it backs up and
  // drops in_ready_o while the sender keeps offering.
  initial begin : receiver
    int rx_cycle;
    int hold_left;
    int mode;
    int mode_left;
    rx_cycle  = 0;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (rx_cycle == 5000 || rx_cycle == 12000) hold_left = 600;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(50, 400);
        end
        mode_left--;
        case (mode)
          0:       out_ready_i <= 1'b1;                         // never stalls
          1:       out_ready_i <= ($urandom_range(0, 3) != 0);  // light stalling
          2:       out_ready_i <= ($urandom_range(0, 9) < 3);   // heavy stalling
          default: out_ready_i <= (rx_cycle % 5 != 0);          // periodic gap
        endcase
      end
    end
  end

  // Offer one request and hold it until the transfer. Called at a rising edge; returns
  // at the edge of the transfer with valid still high.
  task automatic send_request(input logic [1:0] op, input logic [30:0] req_key);
    in_valid_i <= 1'b1;
    func_i     <= op;
    key_i      <= req_key;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic idle_sender(input int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Stop offering until every outstanding answer has come back. The first edge lets
  // the monitor record the request taken at the current edge.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return bhs_pkg::OP_INSERT;
    if (r < 65) return bhs_pkg::OP_SEARCH;
    if (r < 95) return bhs_pkg::OP_DELETE;
    return OP_SPARE;
  endfunction

  // Mostly keys from small per-bucket pools, so buckets fill, overflow and empty
  // again; some fully random keys for bit coverage; a pool at the top of the range.
  function automatic logic [30:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 31'($urandom_range(0, BUCKETS - 1) + BUCKETS * $urandom_range(0, 6));
    if (r < 85) return 31'($urandom());
    return 31'h7FFF_FFFF - 31'($urandom_range(0, 4 * BUCKETS - 1));
  endfunction

  initial begin : stimulus
    int sent;
    int burst;
    int r;
    bit drained;
    sent    = 0;
    drained = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bucket 0 filled, overflowed and partly emptied; delete on an empty
    // bucket; the spare code on hit and miss; extreme and alternating-bit keys.
    send_request(bhs_pkg::OP_SEARCH, 31'd0);
    send_request(bhs_pkg::OP_DELETE, 31'd0);
    send_request(bhs_pkg::OP_INSERT, 31'd0);
    send_request(bhs_pkg::OP_INSERT, 31'd0);
    send_request(bhs_pkg::OP_INSERT, 31'd16);
    send_request(bhs_pkg::OP_INSERT, 31'd32);
    send_request(bhs_pkg::OP_INSERT, 31'd48);
    send_request(bhs_pkg::OP_INSERT, 31'd64);
    send_request(bhs_pkg::OP_SEARCH, 31'd32);
    send_request(OP_SPARE,  31'd48);
    send_request(OP_SPARE,  31'd64);
    send_request(bhs_pkg::OP_DELETE, 31'd16);
    send_request(bhs_pkg::OP_DELETE, 31'd16);
    send_request(bhs_pkg::OP_INSERT, 31'd64);
    send_request(bhs_pkg::OP_SEARCH, 31'd64);
    send_request(bhs_pkg::OP_INSERT, 31'h7FFF_FFFF);
    send_request(bhs_pkg::OP_SEARCH, 31'h7FFF_FFFF);
    send_request(bhs_pkg::OP_SEARCH, 31'h7FFF_FFEF);
    send_request(bhs_pkg::OP_INSERT, 31'h2AAA_AAAA);
    send_request(bhs_pkg::OP_INSERT, 31'h5555_5555);
    send_request(bhs_pkg::OP_DELETE, 31'h7FFF_FFFF);
    send_request(bhs_pkg::OP_SEARCH, 31'h7FFF_FFFF);
    send_request(bhs_pkg::OP_SEARCH, 31'h5555_5555);
    drain_results();

    // Random bursts; gaps of every length up to beyond one request's processing time.
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        send_request(pick_op(), pick_key());
        sent++;
      end
      if (!drained && sent >= RANDOM_ITEMS / 2) begin
        drain_results();
        drained = 1'b1;
      end
      r = $urandom_range(0, 9);
      if (r < 3)      idle_sender(0);
      else if (r < 8) idle_sender($urandom_range(1, 10));
      else            idle_sender($urandom_range(11, 60));
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.pending() != 0) sb.flag($sformatf("%0d results never arrived", sb.pending()));
    $display("requests: %0d insert, %0d search, %0d delete, %0d spare code; %0d hits",
             sb.op_seen[bhs_pkg::OP_INSERT], sb.op_seen[bhs_pkg::OP_SEARCH],
             sb.op_seen[bhs_pkg::OP_DELETE], sb.op_seen[OP_SPARE], sb.hits_seen);
    $display("answers: %0d done, %0d already present, %0d not found, %0d bucket full; %0d failures",
             sb.status_seen[bhs_pkg::ST_DONE], sb.status_seen[bhs_pkg::ST_PRESENT],
             sb.status_seen[bhs_pkg::ST_MISSING], sb.status_seen[bhs_pkg::ST_FULL],
             sb.failures);
    if (sb.failures == 0) begin
      $display("bucketed_hash_set_top_tb OK");
    end else begin
      $display("bucketed_hash_set_top_tb NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/bhs_pkg.sv
rtl/bhs_ram.sv
rtl/bucketed_hash_set_top.sv
bench/bucketed_hash_set_top_tb.sv
